// ===== src/ham_pkg.sv =====
package ham_pkg;

  localparam int H_W       = 32;
  localparam int DIV_W     = 38;
  localparam int DIV_STEPS = 2;
  localparam int FRAC_ONE  = 65536;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_RECALL = 2'd2;

  localparam logic [1:0] REG_LEARN_RULE  = 2'd0;
  localparam logic [1:0] REG_UPDATE_MODE = 2'd1;
  localparam logic [1:0] REG_SWEEP_COUNT = 2'd2;

  localparam logic [1:0] MODE_ASYNC     = 2'd0;
  localparam logic [1:0] MODE_SYNC_CONV = 2'd2;

  localparam logic RULE_STORKEY = 1'b1;

  typedef struct packed {
    logic              rule;
    logic              xi_row;
    logic              div_load;
    logic              div_step;
    logic signed [H_W-1:0] h_row;
  } lane_ctl_t;

endpackage

// ===== src/hopfield_associative_memory.sv =====
// Hopfield associative memory.
// Input channel: a word (kind, pattern) is taken when start is high and busy
// is low. Clear leaves busy low; store and recall hold busy until finished.
// Result channel: a recall returns one word on recalled, sweeps_taken and
// converged, marked by done for exactly one cycle; it cannot be held off.
// Clear and store return nothing, nor does an unknown kind.
// Config channel: cfg_valid/cfg_ready (ready always high), cfg_index selects
// learn_rule, update_mode or sweep_count; write only while idle.
// Structure (N = NEURONS): each weight row is one RAM word; N lanes work on one
// row, a two-stage adder tree merges them. Recall: up to sweep_count sweeps
// of N row fields each, then done (zero sweeps: straight to done). Hebbian
// store: one write per row. Storkey store: a field pass, then per row the
// two-step reciprocal-multiply divide by 2N in every lane and a write.
// A new word is taken the cycle busy drops.
// Reset idles the FSM, clears done, the per-row valid bits (weights read as zero)
// and the config registers but sets sweep_count to 16; no clearing pass is needed.
module hopfield_associative_memory #(
  parameter int NEURONS     = 64,
  parameter int WEIGHT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] pattern,
  output logic        done,
  output logic [63:0] recalled,
  output logic [7:0]  sweeps_taken,
  output logic        converged,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int FIELD_W = WEIGHT_BITS + $clog2(NEURONS) + 1;
  localparam int RW      = $clog2(NEURONS);
  localparam int CW      = $clog2(ham_pkg::DIV_STEPS);
  localparam int ROW_W   = NEURONS * WEIGHT_BITS;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_FADDR = 12'b000000000010,
    S_FDATA = 12'b000000000100,
    S_FSUM1 = 12'b000000001000,
    S_FSUM2 = 12'b000000010000,
    S_HADDR = 12'b000000100000,
    S_HDATA = 12'b000001000000,
    S_KADDR = 12'b000010000000,
    S_KLOAD = 12'b000100000000,
    S_KDIV  = 12'b001000000000,
    S_KWR   = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

  state_t state;

  logic        learn_rule;
  logic [1:0]  update_mode;
  logic [7:0]  sweep_count;

  logic [NEURONS-1:0] cur, nxt, nxt_upd, s_vec, row_valid;
  logic [RW-1:0]      row;
  logic [7:0]         sw;
  logic [CW-1:0]      dcnt;
  logic               is_store, rd_ok;
  logic [7:0]         taken_r;
  logic               conv_r;
  logic signed [ham_pkg::H_W-1:0] h [NEURONS];

  logic              re, we;
  logic [ROW_W-1:0]  rdata, wdata;
  logic signed [FIELD_W-1:0] terms [NEURONS];
  logic signed [FIELD_W-1:0] field;
  logic signed [63:0]        fx;
  logic signed [ham_pkg::H_W-1:0] field_sat;
  ham_pkg::lane_ctl_t ctl;
  logic              last_row;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign re        = (state == S_FADDR) || (state == S_HADDR) || (state == S_KADDR);
  assign we        = (state == S_HDATA) || (state == S_KWR);
  assign last_row  = (row == RW'(NEURONS - 1));
  assign s_vec     = (!is_store && update_mode == ham_pkg::MODE_ASYNC) ? nxt : cur;

  always_comb begin
    ctl.rule     = (state == S_KWR) || (state == S_KLOAD) || (state == S_KDIV);
    ctl.xi_row   = cur[row];
    ctl.div_load = (state == S_KLOAD);
    ctl.div_step = (state == S_KDIV);
    ctl.h_row    = h[row];
  end

  ham_ram #(.WIDTH(ROW_W), .DEPTH(NEURONS)) u_wram (
    .clk  (clk),
    .we   (we),
    .waddr(row),
    .wdata(wdata),
    .re   (re),
    .raddr(row),
    .rdata(rdata)
  );

  for (genvar j = 0; j < NEURONS; j++) begin : g_lane
    logic signed [WEIGHT_BITS-1:0] w_eff, w_new;
    assign w_eff = rd_ok ? rdata[j*WEIGHT_BITS +: WEIGHT_BITS] : '0;
    ham_lane #(.NEURONS(NEURONS), .WEIGHT_BITS(WEIGHT_BITS)) u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .diag  (row == RW'(j)),
      .s_bit (s_vec[j]),
      .xi_col(cur[j]),
      .h_col (h[j]),
      .w     (w_eff),
      .term  (terms[j]),
      .w_new (w_new)
    );
    assign wdata[j*WEIGHT_BITS +: WEIGHT_BITS] = w_new;
  end

  ham_merge #(.NEURONS(NEURONS), .FIELD_W(FIELD_W)) u_merge (
    .clk  (clk),
    .terms(terms),
    .sum  (field)
  );

  always_comb begin
    fx = 64'(field);
    if (fx > 64'sh7FFFFFFF) begin
      field_sat = 32'sh7FFFFFFF;
    end else if (fx < -64'sh80000000) begin
      field_sat = 32'sh80000000;
    end else begin
      field_sat = 32'(fx);
    end
    nxt_upd      = nxt;
    nxt_upd[row] = !field[FIELD_W-1];
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_ok <= row_valid[row];
    end
    if (state == S_FSUM2 && is_store) begin
      h[row] <= field_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      learn_rule  <= 1'b0;
      update_mode <= ham_pkg::MODE_ASYNC;
      sweep_count <= 8'd16;
      row_valid   <= '0;
      done        <= 1'b0;
      row         <= '0;
      sw          <= '0;
      dcnt        <= '0;
      is_store    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          ham_pkg::REG_LEARN_RULE:  learn_rule  <= cfg_data[0];
          ham_pkg::REG_UPDATE_MODE: update_mode <= cfg_data[1:0];
          ham_pkg::REG_SWEEP_COUNT: sweep_count <= cfg_data;
          default: ;
        endcase
      end
      if (we) begin
        row_valid[row] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            row <= '0;
            sw  <= '0;
            cur <= pattern[NEURONS-1:0];
            nxt <= pattern[NEURONS-1:0];
            unique case (kind)
              ham_pkg::KIND_CLEAR: row_valid <= '0;
              ham_pkg::KIND_STORE: begin
                is_store <= 1'b1;
                state    <= (learn_rule == ham_pkg::RULE_STORKEY) ? S_FADDR : S_HADDR;
              end
              ham_pkg::KIND_RECALL: begin
                is_store <= 1'b0;
                taken_r  <= '0;
                conv_r   <= 1'b0;
                state    <= (sweep_count == 8'd0) ? S_FIN : S_FADDR;
              end
              default: ;
            endcase
          end
        end
        S_FADDR: state <= S_FDATA;
        S_FDATA: state <= S_FSUM1;
        S_FSUM1: state <= S_FSUM2;
        S_FSUM2: begin
          row <= last_row ? '0 : RW'(row + 1'b1);
          if (is_store) begin
            state <= last_row ? S_KADDR : S_FADDR;
          end else begin
            nxt   <= nxt_upd;
            state <= S_FADDR;
            if (last_row) begin
              cur     <= nxt_upd;
              taken_r <= 8'(sw + 1'b1);
              if (update_mode == ham_pkg::MODE_SYNC_CONV && nxt_upd == cur) begin
                conv_r <= 1'b1;
                state  <= S_FIN;
              end else if (8'(sw + 1'b1) == sweep_count) begin
                state <= S_FIN;
              end else begin
                sw <= 8'(sw + 1'b1);
              end
            end
          end
        end
        S_HADDR: state <= S_HDATA;
        S_HDATA: begin
          row   <= RW'(row + 1'b1);
          state <= last_row ? S_IDLE : S_HADDR;
        end
        S_KADDR: state <= S_KLOAD;
        S_KLOAD: begin
          dcnt  <= '0;
          state <= S_KDIV;
        end
        S_KDIV: begin
          dcnt <= CW'(dcnt + 1'b1);
          if (dcnt == CW'(ham_pkg::DIV_STEPS - 1)) begin
            state <= S_KWR;
          end
        end
        S_KWR: begin
          row   <= RW'(row + 1'b1);
          state <= last_row ? S_IDLE : S_KADDR;
        end
        S_FIN: begin
          done         <= 1'b1;
          recalled     <= 64'(cur);
          sweeps_taken <= taken_r;
          converged    <= conv_r;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ham_ram.sv =====
module ham_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ham_lane.sv =====
module ham_lane #(
  parameter int NEURONS     = 64,
  parameter int WEIGHT_BITS = 24
) (
  input  logic                                           clk,
  input  ham_pkg::lane_ctl_t                             ctl,
  input  logic                                           diag,
  input  logic                                           s_bit,
  input  logic                                           xi_col,
  input  logic signed [ham_pkg::H_W-1:0]                 h_col,
  input  logic signed [WEIGHT_BITS-1:0]                  w,
  output logic signed [WEIGHT_BITS+$clog2(NEURONS):0]    term,
  output logic signed [WEIGHT_BITS-1:0]                  w_new
);

  localparam int FIELD_W = WEIGHT_BITS + $clog2(NEURONS) + 1;
  localparam int DW      = ham_pkg::DIV_W;
  localparam int DIVISOR = 2 * NEURONS;
  localparam int UW      = DW - 3;
  localparam int MW      = UW + 2;
  localparam int PW      = UW + MW;
  localparam int LO_W    = 18;
  localparam int SH      = UW + $clog2(DIVISOR);
  localparam int QW      = UW - $clog2(DIVISOR) + 1;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam int INC     = (2 * ham_pkg::FRAC_ONE + NEURONS) / (2 * NEURONS);
  localparam int SUM_W   = DW + 2;
  localparam logic signed [SUM_W-1:0] W_MAX =
    SUM_W'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] W_MIN = -W_MAX - SUM_W'(1);

  logic signed [DW-1:0]    num, a_val;
  logic [UW-1:0]           u_load, u_r;
  logic                    neg_r;
  logic [PW-1:0]           pl_r, ph_r, psum;
  logic [QW-1:0]           q_r;
  logic signed [DW-1:0]    qs;
  logic signed [SUM_W-1:0] hsum, ksum, sum;

  assign term = diag ? '0 : (s_bit ? FIELD_W'(w) : -FIELD_W'(w));

  always_comb begin
    num = (ctl.xi_row == xi_col) ? DW'(ham_pkg::FRAC_ONE) : -DW'(ham_pkg::FRAC_ONE);
    num = num - (ctl.xi_row ? DW'(h_col) : -DW'(h_col));
    num = num - (xi_col ? DW'(ctl.h_row) : -DW'(ctl.h_row));
    a_val = (num <<< 1) + DW'(NEURONS);
    u_load = a_val[DW-1] ? UW'(-a_val + DW'(DIVISOR - 1)) : UW'(a_val);
  end

  // divide by 2N: reciprocal multiply, products then quotient
  assign psum = pl_r + (ph_r << LO_W);

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      u_r   <= u_load;
      neg_r <= a_val[DW-1];
    end else if (ctl.div_step) begin
      pl_r <= PW'(u_r[LO_W-1:0]) * PW'(RECIP);
      ph_r <= PW'(u_r[UW-1:LO_W]) * PW'(RECIP);
      q_r  <= psum[SH +: QW];
    end
  end

  always_comb begin
    qs   = neg_r ? -$signed(DW'(q_r)) : $signed(DW'(q_r));
    hsum = SUM_W'(w) + ((ctl.xi_row == xi_col) ? SUM_W'(INC) : -SUM_W'(INC));
    ksum = SUM_W'(w) + SUM_W'(qs);
    sum  = ctl.rule ? ksum : hsum;
    if (diag) begin
      w_new = w;
    end else if (sum > W_MAX) begin
      w_new = WEIGHT_BITS'(W_MAX);
    end else if (sum < W_MIN) begin
      w_new = WEIGHT_BITS'(W_MIN);
    end else begin
      w_new = WEIGHT_BITS'(sum);
    end
  end

endmodule

// ===== src/ham_merge.sv =====
module ham_merge #(
  parameter int NEURONS = 64,
  parameter int FIELD_W = 31
) (
  input  logic                      clk,
  input  logic signed [FIELD_W-1:0] terms [NEURONS],
  output logic signed [FIELD_W-1:0] sum
);

  localparam int GROUPS = (NEURONS + 7) / 8;

  logic signed [FIELD_W-1:0] part_next [GROUPS];
  logic signed [FIELD_W-1:0] part      [GROUPS];
  logic signed [FIELD_W-1:0] sum_next;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_next[g] = '0;
      for (int k = 0; k < 8; k++) begin
        if (g * 8 + k < NEURONS) begin
          part_next[g] = part_next[g] + terms[g * 8 + k];
        end
      end
    end
    sum_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_next = sum_next + part[g];
    end
  end

  always_ff @(posedge clk) begin
    part <= part_next;
    sum  <= sum_next;
  end

endmodule

// ===== src/ham_checker.sv =====
module ham_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] kind,
  input logic       done,
  input logic [7:0] sweeps_taken,
  input logic       converged
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");

  a_recall_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == ham_pkg::KIND_RECALL) |=> busy)
    else $error("recall accepted without going busy");

  a_conv_sweeps: assert property (@(posedge clk) disable iff (rst)
    (done && converged) |-> (sweeps_taken != 8'd0))
    else $error("converged with zero sweeps");

endmodule

bind hopfield_associative_memory ham_checker u_ham_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .kind        (kind),
  .done        (done),
  .sweeps_taken(sweeps_taken),
  .converged   (converged)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = 64;
  localparam int WB = 24;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [1:0] MODE_SYNC = 2'd1;
  localparam logic [1:0] MODE_ODD = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] kind = '0;
  logic [63:0] pattern = '0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic busy, done, converged, cfg_ready;
  logic [63:0] recalled;
  logic [7:0] sweeps_taken;

  hopfield_associative_memory dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .pattern(pattern),
    .done(done), .recalled(recalled), .sweeps_taken(sweeps_taken), .converged(converged),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [63:0] state;
    logic [7:0] sweeps;
    logic conv;
  } recall_word_t;

  recall_word_t recall_q[$];
  int errors = 0;
  int n_recalls = 0;
  int n_stores = 0;
  int gap_pct = 0;

  logic rule_sh;
  logic [1:0] mode_sh;
  logic [7:0] count_sh;
  int weight_mem[N*N];
  logic [63:0] stored[$];

  function automatic longint div_n(longint num);
    longint a, b, q;
    a = 2 * num + N;
    b = 2 * N;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic int wclip(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (WB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return int'(hi);
    if (v < lo) return int'(lo);
    return int'(v);
  endfunction

  function automatic longint bip(logic [63:0] v, int i);
    return v[i] ? 64'sd1 : -64'sd1;
  endfunction

  function automatic longint row_field(int row, logic [63:0] s);
    longint sum;
    sum = 0;
    for (int k = 0; k < N; k++)
      if (k != row) sum += longint'(weight_mem[row*N+k]) * bip(s, k);
    return sum;
  endfunction

  task automatic learn_pattern(logic [63:0] p);
    int h[N];
    longint f, num;
    if (!rule_sh) begin
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++)
          if (i != j)
            weight_mem[i*N+j] = wclip(longint'(weight_mem[i*N+j])
                                      + bip(p, i) * bip(p, j) * div_n(ham_pkg::FRAC_ONE));
    end else begin
      for (int i = 0; i < N; i++) begin
        f = row_field(i, p);
        if (f > 64'sd2147483647) h[i] = 32'h7fffffff;
        else if (f < -64'sd2147483648) h[i] = 32'h80000000;
        else h[i] = int'(f);
      end
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++)
          if (i != j) begin
            num = bip(p, i) * bip(p, j) * ham_pkg::FRAC_ONE - bip(p, i) * longint'(h[j])
                  - longint'(h[i]) * bip(p, j);
            weight_mem[i*N+j] = wclip(longint'(weight_mem[i*N+j]) + div_n(num));
          end
    end
  endtask

  function automatic recall_word_t settle_cue(logic [63:0] cue);
    recall_word_t r;
    logic [63:0] s, nxt;
    s = cue;
    r.sweeps = '0;
    r.conv = 1'b0;
    for (int step = 0; step < count_sh; step++) begin
      r.sweeps = 8'(step + 1);
      if (mode_sh == ham_pkg::MODE_ASYNC) begin
        for (int i = 0; i < N; i++) s[i] = (row_field(i, s) >= 0);
      end else begin
        for (int i = 0; i < N; i++) nxt[i] = (row_field(i, s) >= 0);
        if (mode_sh == ham_pkg::MODE_SYNC_CONV && nxt == s) begin
          r.conv = 1'b1;
          break;
        end
        s = nxt;
      end
    end
    r.state = s;
    return r;
  endfunction

  task automatic send_item(logic [1:0] k, logic [63:0] p);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    pattern <= p;
    do @(posedge clk); while (busy);
    case (k)
      ham_pkg::KIND_CLEAR: foreach (weight_mem[i]) weight_mem[i] = 0;
      ham_pkg::KIND_STORE: begin
        learn_pattern(p);
        n_stores++;
      end
      ham_pkg::KIND_RECALL: begin
        recall_q.push_back(settle_cue(p));
        n_recalls++;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (recall_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ham_pkg::REG_LEARN_RULE: rule_sh = val[0];
      ham_pkg::REG_UPDATE_MODE: mode_sh = val[1:0];
      ham_pkg::REG_SWEEP_COUNT: count_sh = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic r, logic [1:0] m, logic [7:0] c);
    drain();
    write_reg(ham_pkg::REG_LEARN_RULE, {7'd0, r});
    write_reg(ham_pkg::REG_UPDATE_MODE, {6'd0, m});
    write_reg(ham_pkg::REG_SWEEP_COUNT, c);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (recall_q.size() == 0) begin
        $error("recall word with none pending");
        errors++;
      end else begin
        recall_word_t e;
        e = recall_q.pop_front();
        if (recalled !== e.state) begin
          $error("recalled exp %h got %h", e.state, recalled);
          errors++;
        end
        if (sweeps_taken !== e.sweeps) begin
          $error("sweeps_taken exp %0d got %0d", e.sweeps, sweeps_taken);
          errors++;
        end
        if (converged !== e.conv) begin
          $error("converged exp %0b got %0b", e.conv, converged);
          errors++;
        end
      end
    end
  end

  task automatic test_hebbian();
    send_item(ham_pkg::KIND_RECALL, 64'h0123_4567_89ab_cdef);
    send_item(ham_pkg::KIND_STORE, '1);
    send_item(ham_pkg::KIND_STORE, '0);
    send_item(ham_pkg::KIND_STORE, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(ham_pkg::KIND_RECALL, 64'haaaa_aaaa_aaaa_aaab);
    send_item(ham_pkg::KIND_RECALL, '0);
    send_item(KIND_UNKNOWN, '1);
    send_item(ham_pkg::KIND_CLEAR, '0);
    send_item(ham_pkg::KIND_RECALL, 64'h5555_0000_ffff_1234);
  endtask

  task automatic test_modes();
    set_regs(1'b0, MODE_SYNC, 8'd0);
    send_item(ham_pkg::KIND_STORE, 64'hf0f0_f0f0_0f0f_0f0f);
    send_item(ham_pkg::KIND_RECALL, 64'h8000_0000_0000_0001);
    set_regs(1'b0, MODE_SYNC, 8'd255);
    send_item(ham_pkg::KIND_RECALL, 64'hf0f0_f0f0_0f0f_0f0e);
    set_regs(1'b0, ham_pkg::MODE_SYNC_CONV, 8'd255);
    send_item(ham_pkg::KIND_RECALL, 64'hf0f0_f0f0_0f0f_0f00);
    set_regs(1'b0, ham_pkg::MODE_SYNC_CONV, 8'd1);
    send_item(ham_pkg::KIND_RECALL, 64'h00f0_f0f0_0f0f_0f00);
    set_regs(1'b0, MODE_ODD, 8'd3);
    send_item(ham_pkg::KIND_RECALL, 64'h1234_5678_9abc_def0);
  endtask

  task automatic test_storkey();
    set_regs(1'b1, ham_pkg::MODE_ASYNC, 8'd4);
    send_item(ham_pkg::KIND_CLEAR, '0);
    send_item(ham_pkg::KIND_STORE, 64'hdead_beef_0bad_f00d);
    send_item(ham_pkg::KIND_STORE, 64'h0123_4567_89ab_cdef);
    send_item(ham_pkg::KIND_STORE, '1);
    send_item(ham_pkg::KIND_RECALL, 64'hdead_beef_0bad_f00c);
    set_regs(1'b1, ham_pkg::MODE_SYNC_CONV, 8'd8);
    send_item(ham_pkg::KIND_RECALL, 64'h0123_4567_89ab_cdee);
  endtask

  task automatic test_random(int items);
    int pick;
    logic [63:0] p, mask;
    for (int n = 0; n < items; n++) begin
      if (n == items / 3) gap_pct = 86;
      if (n == 2 * items / 3) gap_pct = 0;
      if (n % 40 == 0)
        set_regs(1'($urandom_range(1)), 2'($urandom_range(3)),
                 ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6)));
      pick = $urandom_range(99);
      p = {$urandom, $urandom};
      if (pick < 3) begin
        send_item(ham_pkg::KIND_CLEAR, p);
        stored.delete();
      end else if (pick < 6) begin
        send_item(KIND_UNKNOWN, p);
      end else if (pick < 30) begin
        send_item(ham_pkg::KIND_STORE, p);
        stored.push_back(p);
      end else if (pick < 85 && stored.size() != 0) begin
        mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        send_item(ham_pkg::KIND_RECALL, stored[$urandom_range(stored.size() - 1)] ^ mask);
      end else begin
        send_item(ham_pkg::KIND_RECALL, p);
      end
    end
  endtask

  initial begin
    foreach (weight_mem[i]) weight_mem[i] = 0;
    rule_sh = 1'b0;
    mode_sh = ham_pkg::MODE_ASYNC;
    count_sh = 8'd16;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_pct = 11;
    test_hebbian();
    test_modes();
    test_storkey();
    gap_pct = 11;
    test_random(558);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d stores and %0d recalls over both rules and all update modes",
             n_stores, n_recalls);
    if (errors == 0 && recall_q.size() == 0)
      $display("hopfield_associative_memory regression: pass");
    else
      $display("hopfield_associative_memory regression: fail");
    $finish;
  end

  initial begin
    #2000ms;
    $display("hopfield_associative_memory regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
src/ham_pkg.sv
src/ham_ram.sv
src/ham_lane.sv
src/ham_merge.sv
src/hopfield_associative_memory.sv
src/ham_checker.sv
tb/sv/tb_top.sv
